// File: rtl/core/block_min_max_mean_stats_top_macros.svh
// assertion macros shared by the tiled statistics rtl
// no dependencies; included by modules that carry concurrent checks
`ifndef BLOCK_MIN_MAX_MEAN_STATS_TOP_MACROS_SVH
`define BLOCK_MIN_MAX_MEAN_STATS_TOP_MACROS_SVH

// same-cycle implication, checks held off during reset
`define BMMS_ASSERT_IMP(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("bmms check failed");

// next-cycle implication, checks held off during reset
`define BMMS_ASSERT_NXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("bmms check failed");

`endif

// File: rtl/core/bmms_pkg.sv
// shared constants, types and codes for the tiled block statistics core
// no dependencies
package bmms_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_BLOCK  = 256;

  localparam int PIX_W   = 8;
  localparam int COORD_W = 12;
  localparam int SUM_W   = 24;
  localparam int CNT_W   = 17;
  localparam int DIM_W   = 13;
  localparam int BLK_W   = 9;
  localparam int INBLK_W = 8;
  localparam int SLOT_W  = $clog2(MAX_WIDTH);
  localparam int ACC_W   = 2 * PIX_W + SUM_W + CNT_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_HEIGHT = 3'd3;

  localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST  = 13'd1024;
  localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST = 13'd1024;
  localparam logic [BLK_W-1:0] BLOCK_WIDTH_RST  = 9'd1;
  localparam logic [BLK_W-1:0] BLOCK_HEIGHT_RST = 9'd1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // quotient of (sum << 8) / count always fits 16 bits since mean <= 255
  localparam int QUOT_W    = 2 * PIX_W;
  localparam int DIV_STEPS = QUOT_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [PIX_W-1:0] mn;
    logic [PIX_W-1:0] mx;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
  } acc_t;

  typedef struct packed {
    logic               first;
    logic               last;
    logic [COORD_W-1:0] block_row;
    logic [COORD_W-1:0] block_col;
    logic [PIX_W-1:0]   pixel;
  } cmd_t;

  typedef struct packed {
    logic [COORD_W-1:0] block_row;
    logic [COORD_W-1:0] block_col;
    logic [PIX_W-1:0]   block_min;
    logic [PIX_W-1:0]   block_max;
    logic [SUM_W-1:0]   pixel_sum;
    logic [CNT_W-1:0]   pixel_count;
    logic [PIX_W-1:0]   mean_int;
    logic [PIX_W-1:0]   mean_frac;
  } stats_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_UPDATE,
    BK_DIVIDE,
    BK_EMIT
  } back_state_t;

endpackage

// File: rtl/core/bmms_ifs.sv
// valid/ready channel interfaces: pixel input, configuration write, block results
// depends on bmms_pkg
interface bmms_pixel_if import bmms_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;
  modport source(output valid, output pixel_value, input ready);
  modport sink(input valid, input pixel_value, output ready);
endinterface

interface bmms_cfg_if import bmms_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] write_data;
  modport source(output valid, output reg_index, output write_data, input ready);
  modport sink(input valid, input reg_index, input write_data, output ready);
endinterface

interface bmms_stats_if import bmms_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] block_row;
  logic [COORD_W-1:0] block_col;
  logic [PIX_W-1:0]   block_min;
  logic [PIX_W-1:0]   block_max;
  logic [SUM_W-1:0]   pixel_sum;
  logic [CNT_W-1:0]   pixel_count;
  logic [PIX_W-1:0]   mean_int;
  logic [PIX_W-1:0]   mean_frac;
  modport source(output valid, output block_row, output block_col, output block_min,
                 output block_max, output pixel_sum, output pixel_count,
                 output mean_int, output mean_frac, input ready);
  modport sink(input valid, input block_row, input block_col, input block_min,
               input block_max, input pixel_sum, input pixel_count,
               input mean_int, input mean_frac, output ready);
endinterface

// File: rtl/core/block_min_max_mean_stats_top.sv
// tiled block min/max/sum/mean statistics over a raster pixel stream
// each pixel passes the queue, then the accumulator ram read-modify-write (idle, update);
//   a tile-closing pixel then runs the 16-step serial divider and waits in emit for a free
//   result register, and the back end takes no new pixel until that tile is loaded
// reset: rst (synchronous, active high) loads default sizes, clears position,
//   queue and result valid; accumulator ram is not cleared, each tile's first pixel writes it
module block_min_max_mean_stats_top import bmms_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  bmms_pixel_if.sink   pixel,
  bmms_cfg_if.sink     cfg,
  bmms_stats_if.source stats
);

  // classified pixel transaction from front end to queue
  cmd_t front_cmd;
  logic front_push;
  logic queue_full;

  // queue to back end
  cmd_t queue_data;
  logic queue_empty;
  logic queue_pop;

  // front end: config registers, position counters, first/last-of-tile flags,
  // tile coordinates; stalls only when the queue is full
  bmms_front u_front (
    .clk      (clk),
    .rst      (rst),
    .pixel    (pixel),
    .cfg      (cfg),
    .cmd      (front_cmd),
    .cmd_push (front_push),
    .cmd_full (queue_full)
  );

  // short queue decouples pixel intake from accumulator and divider work
  bmms_cmd_fifo u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_push),
    .push_data (front_cmd),
    .full      (queue_full),
    .pop       (queue_pop),
    .pop_data  (queue_data),
    .empty     (queue_empty)
  );

  // back end: per-column accumulators in ram, mean divider and result register;
  // the result register holds a finished tile while the next pixels proceed
  bmms_back u_back (
    .clk        (clk),
    .rst        (rst),
    .fifo_data  (queue_data),
    .fifo_empty (queue_empty),
    .fifo_pop   (queue_pop),
    .stats      (stats)
  );

endmodule

// File: rtl/core/bmms_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
module bmms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/bmms_front.sv
// front end: config registers, raster position tracking, pixel classification
// depends on bmms_pkg and the channel interfaces
module bmms_front import bmms_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  bmms_pixel_if.sink     pixel,
  bmms_cfg_if.sink       cfg,
  output cmd_t           cmd,
  output logic           cmd_push,
  input  logic           cmd_full
);

  localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);
  localparam logic [BLK_W-1:0] MAX_B_DIM = BLK_W'(MAX_BLOCK);

  logic [DIM_W-1:0]   image_width;
  logic [DIM_W-1:0]   image_height;
  logic [BLK_W-1:0]   block_width;
  logic [BLK_W-1:0]   block_height;

  logic [COORD_W-1:0] col_pos;
  logic [COORD_W-1:0] row_pos;
  logic [INBLK_W-1:0] col_in_blk;
  logic [INBLK_W-1:0] row_in_blk;
  logic [COORD_W-1:0] blk_col;
  logic [COORD_W-1:0] blk_row;

  logic [DIM_W-1:0]   width_eff;
  logic [DIM_W-1:0]   height_eff;
  logic [BLK_W-1:0]   bw_eff;
  logic [BLK_W-1:0]   bh_eff;

  logic col_end;
  logic row_end;
  logic blk_col_end;
  logic blk_row_end;
  logic accept;
  logic restart;

  // zero sizes act as one, oversize values saturate
  always_comb begin
    width_eff  = (image_width == '0) ? DIM_W'(1) :
                 (image_width > MAX_W_DIM) ? MAX_W_DIM : image_width;
    height_eff = (image_height == '0) ? DIM_W'(1) :
                 (image_height > MAX_H_DIM) ? MAX_H_DIM : image_height;
    bw_eff     = (block_width == '0) ? BLK_W'(1) :
                 (block_width > MAX_B_DIM) ? MAX_B_DIM : block_width;
    bh_eff     = (block_height == '0) ? BLK_W'(1) :
                 (block_height > MAX_B_DIM) ? MAX_B_DIM : block_height;
  end

  assign col_end     = (DIM_W'(col_pos) + DIM_W'(1)) >= width_eff;
  assign row_end     = (DIM_W'(row_pos) + DIM_W'(1)) >= height_eff;
  assign blk_col_end = (BLK_W'(col_in_blk) + BLK_W'(1)) >= bw_eff;
  assign blk_row_end = (BLK_W'(row_in_blk) + BLK_W'(1)) >= bh_eff;

  assign cfg.ready   = 1'b1;
  assign restart     = cfg.valid && (cfg.reg_index <= CFG_BLOCK_HEIGHT);
  assign pixel.ready = !cmd_full;
  assign accept      = pixel.valid && !cmd_full;
  assign cmd_push    = accept;

  always_comb begin
    cmd.first     = (col_in_blk == '0) && (row_in_blk == '0);
    cmd.last      = (blk_col_end || col_end) && (blk_row_end || row_end);
    cmd.block_row = blk_row;
    cmd.block_col = blk_col;
    cmd.pixel     = pixel.pixel_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RST;
      image_height <= IMAGE_HEIGHT_RST;
      block_width  <= BLOCK_WIDTH_RST;
      block_height <= BLOCK_HEIGHT_RST;
      col_pos      <= '0;
      row_pos      <= '0;
      col_in_blk   <= '0;
      row_in_blk   <= '0;
      blk_col      <= '0;
      blk_row      <= '0;
    end else begin
      if (cfg.valid) begin
        case (cfg.reg_index)
          CFG_IMAGE_WIDTH:  image_width  <= cfg.write_data[DIM_W-1:0];
          CFG_IMAGE_HEIGHT: image_height <= cfg.write_data[DIM_W-1:0];
          CFG_BLOCK_WIDTH:  block_width  <= cfg.write_data[BLK_W-1:0];
          CFG_BLOCK_HEIGHT: block_height <= cfg.write_data[BLK_W-1:0];
          default: ;
        endcase
      end
      if (restart) begin
        col_pos    <= '0;
        row_pos    <= '0;
        col_in_blk <= '0;
        row_in_blk <= '0;
        blk_col    <= '0;
        blk_row    <= '0;
      end else if (accept) begin
        if (col_end) begin
          col_pos    <= '0;
          col_in_blk <= '0;
          blk_col    <= '0;
          if (row_end) begin
            row_pos    <= '0;
            row_in_blk <= '0;
            blk_row    <= '0;
          end else begin
            row_pos <= row_pos + COORD_W'(1);
            if (blk_row_end) begin
              row_in_blk <= '0;
              blk_row    <= blk_row + COORD_W'(1);
            end else begin
              row_in_blk <= row_in_blk + INBLK_W'(1);
            end
          end
        end else begin
          col_pos <= col_pos + COORD_W'(1);
          if (blk_col_end) begin
            col_in_blk <= '0;
            blk_col    <= blk_col + COORD_W'(1);
          end else begin
            col_in_blk <= col_in_blk + INBLK_W'(1);
          end
        end
      end
    end
  end

endmodule

// File: rtl/core/bmms_cmd_fifo.sv
// small command queue between front end and back end
// depends on bmms_pkg and the assertion macro header
`include "block_min_max_mean_stats_top_macros.svh"

module bmms_cmd_fifo import bmms_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  cmd_t               entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;

  assign full     = count == (FIFO_AW + 1)'(FIFO_DEPTH);
  assign empty    = count == '0;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (FIFO_AW + 1)'(1);
        2'b01:   count <= count - (FIFO_AW + 1)'(1);
        default: ;
      endcase
    end
  end

  `BMMS_ASSERT_IMP(a_no_push_when_full, clk, rst, push, !full)
  `BMMS_ASSERT_IMP(a_no_pop_when_empty, clk, rst, pop, !empty)
  `BMMS_ASSERT_NXT(a_push_fills, clk, rst, push && !pop, !empty)

endmodule

// File: rtl/core/bmms_back.sv
// back end: accumulator read-modify-write, serial mean divider, result register
// depends on bmms_pkg, bmms_ram, the channel interfaces and the macro header
`include "block_min_max_mean_stats_top_macros.svh"

module bmms_back import bmms_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  cmd_t          fifo_data,
  input  logic          fifo_empty,
  output logic          fifo_pop,
  bmms_stats_if.source  stats
);

  back_state_t       state;
  back_state_t       state_next;
  cmd_t              cmd_r;
  acc_t              acc_r;
  acc_t              acc_new;
  acc_t              acc_old;
  logic [ACC_W-1:0]  ram_rdata;
  logic [QUOT_W-1:0] rem;
  logic [QUOT_W-1:0] dvd;
  logic [QUOT_W-1:0] quot;
  logic [STEP_W-1:0] step;
  logic [QUOT_W:0]   rem_sh;
  logic              fits;
  logic [QUOT_W-1:0] rem_next;
  logic              load_out;
  logic              out_valid;
  stats_t            out_r;

  bmms_ram #(
    .WIDTH(ACC_W),
    .DEPTH(MAX_WIDTH)
  ) u_acc_ram (
    .clk     (clk),
    .wr_en   (state == BK_UPDATE),
    .wr_addr (cmd_r.block_col[SLOT_W-1:0]),
    .wr_data (acc_new),
    .rd_en   (fifo_pop),
    .rd_addr (fifo_data.block_col[SLOT_W-1:0]),
    .rd_data (ram_rdata)
  );

  assign acc_old = acc_t'(ram_rdata);

  // first pixel of a tile overwrites the column entry
  always_comb begin
    if (cmd_r.first) begin
      acc_new.mn  = cmd_r.pixel;
      acc_new.mx  = cmd_r.pixel;
      acc_new.sum = SUM_W'(cmd_r.pixel);
      acc_new.cnt = CNT_W'(1);
    end else begin
      acc_new.mn  = (cmd_r.pixel < acc_old.mn) ? cmd_r.pixel : acc_old.mn;
      acc_new.mx  = (cmd_r.pixel > acc_old.mx) ? cmd_r.pixel : acc_old.mx;
      acc_new.sum = acc_old.sum + SUM_W'(cmd_r.pixel);
      acc_new.cnt = acc_old.cnt + CNT_W'(1);
    end
  end

  // restoring division step, one quotient bit per cycle
  assign rem_sh   = {rem, dvd[QUOT_W-1]};
  assign fits     = rem_sh >= acc_r.cnt;
  assign rem_next = fits ? QUOT_W'(rem_sh - acc_r.cnt) : rem_sh[QUOT_W-1:0];

  assign load_out = (state == BK_EMIT) && (!out_valid || stats.ready);

  always_comb begin
    state_next = state;
    fifo_pop   = 1'b0;
    case (state)
      BK_IDLE: begin
        if (!fifo_empty) begin
          fifo_pop   = 1'b1;
          state_next = BK_UPDATE;
        end
      end
      BK_UPDATE: begin
        state_next = cmd_r.last ? BK_DIVIDE : BK_IDLE;
      end
      BK_DIVIDE: begin
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (load_out) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (stats.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_pop) begin
      cmd_r <= fifo_data;
    end
    if (state == BK_UPDATE && cmd_r.last) begin
      acc_r <= acc_new;
      // top bits of sum are already below count, so start there
      rem   <= acc_new.sum[SUM_W-1:PIX_W];
      dvd   <= {acc_new.sum[PIX_W-1:0], PIX_W'(0)};
      quot  <= '0;
      step  <= '0;
    end
    if (state == BK_DIVIDE) begin
      rem  <= rem_next;
      dvd  <= {dvd[QUOT_W-2:0], 1'b0};
      quot <= {quot[QUOT_W-2:0], fits};
      step <= step + STEP_W'(1);
    end
    if (load_out) begin
      out_r.block_row   <= cmd_r.block_row;
      out_r.block_col   <= cmd_r.block_col;
      out_r.block_min   <= acc_r.mn;
      out_r.block_max   <= acc_r.mx;
      out_r.pixel_sum   <= acc_r.sum;
      out_r.pixel_count <= acc_r.cnt;
      out_r.mean_int    <= quot[QUOT_W-1:PIX_W];
      out_r.mean_frac   <= quot[PIX_W-1:0];
    end
  end

  assign stats.valid       = out_valid;
  assign stats.block_row   = out_r.block_row;
  assign stats.block_col   = out_r.block_col;
  assign stats.block_min   = out_r.block_min;
  assign stats.block_max   = out_r.block_max;
  assign stats.pixel_sum   = out_r.pixel_sum;
  assign stats.pixel_count = out_r.pixel_count;
  assign stats.mean_int    = out_r.mean_int;
  assign stats.mean_frac   = out_r.mean_frac;

  `BMMS_ASSERT_IMP(a_mean_in_range, clk, rst, out_valid, (out_r.mean_int >= out_r.block_min) && (out_r.mean_int <= out_r.block_max))
  `BMMS_ASSERT_IMP(a_rem_below_count, clk, rst, state == BK_DIVIDE, CNT_W'(rem) < acc_r.cnt)
  `BMMS_ASSERT_NXT(a_pop_then_update, clk, rst, fifo_pop, state == BK_UPDATE)

endmodule

// File: bench/testbench.sv
// self-checking bench for block_min_max_mean_stats_top: raster pixels in, tile statistics out
// depends on bmms_pkg and the bmms channel interfaces from the rtl tree
// a scoreboard class predicts each tile result; plain tasks drive pixels and register writes
module testbench;
  import bmms_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

  localparam int SETTLE_CYCLES  = 40;       // idle wait once every tile result is back
  localparam int DRAIN_LIMIT    = 20000;    // cycles to wait for outstanding tiles
  localparam int HOLD_CYCLES    = 300;      // long result-side hold-off
  localparam int RANDOM_PIXELS  = 550;
  localparam int MISMATCH_SHOWN = 10;
  localparam longint TIMEOUT_NS = 2_000_000;

  // tile statistics predictor and result checker
  class tile_stats_scoreboard;
    logic [DIM_W-1:0] image_w = IMAGE_WIDTH_RST;
    logic [DIM_W-1:0] image_h = IMAGE_HEIGHT_RST;
    logic [BLK_W-1:0] tile_w  = BLOCK_WIDTH_RST;
    logic [BLK_W-1:0] tile_h  = BLOCK_HEIGHT_RST;
    int unsigned col_pos, row_pos, col_in_tile, row_in_tile, col_tile;
    acc_t        tile_acc [MAX_WIDTH];
    stats_t      expected_tiles [$];
    int unsigned failures, tiles_predicted, tiles_checked;

    function int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned image_area();
      return clamp_dim(32'(image_w), MAX_WIDTH) * clamp_dim(32'(image_h), MAX_HEIGHT);
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= MISMATCH_SHOWN) $display("%s", msg);
    endfunction

    // register write; known indexes also restart the image at its top-left pixel
    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_IMAGE_WIDTH:  image_w = data[DIM_W-1:0];
        CFG_IMAGE_HEIGHT: image_h = data[DIM_W-1:0];
        CFG_BLOCK_WIDTH:  tile_w  = data[BLK_W-1:0];
        CFG_BLOCK_HEIGHT: tile_h  = data[BLK_W-1:0];
        default: return;
      endcase
      col_pos = 0;
      row_pos = 0;
      col_in_tile = 0;
      row_in_tile = 0;
      col_tile = 0;
    endfunction

    function void note_pixel(logic [PIX_W-1:0] px);
      int unsigned     w, h, bw, bh;
      bit              last_col, last_row;
      acc_t            a;
      stats_t          t;
      longint unsigned scaled;
      w  = clamp_dim(32'(image_w), MAX_WIDTH);
      h  = clamp_dim(32'(image_h), MAX_HEIGHT);
      bw = clamp_dim(32'(tile_w), MAX_BLOCK);
      bh = clamp_dim(32'(tile_h), MAX_BLOCK);
      if (col_in_tile == 0 && row_in_tile == 0) begin
        a.mn  = px;
        a.mx  = px;
        a.sum = SUM_W'(px);
        a.cnt = CNT_W'(1);
      end else begin
        a = tile_acc[col_tile];
        if (px < a.mn) a.mn = px;
        if (px > a.mx) a.mx = px;
        a.sum = a.sum + SUM_W'(px);
        a.cnt = a.cnt + CNT_W'(1);
      end
      tile_acc[col_tile] = a;
      last_col = (col_in_tile + 1 >= bw) || (col_pos + 1 >= w);
      last_row = (row_in_tile + 1 >= bh) || (row_pos + 1 >= h);
      if (last_col && last_row) begin
        scaled = 0;
        if (a.cnt != 0) scaled = ({40'd0, a.sum} << 8) / 64'(a.cnt);
        t.block_row   = COORD_W'(row_pos / bh);
        t.block_col   = COORD_W'(col_tile);
        t.block_min   = a.mn;
        t.block_max   = a.mx;
        t.pixel_sum   = a.sum;
        t.pixel_count = a.cnt;
        t.mean_int    = scaled[15:8];
        t.mean_frac   = scaled[7:0];
        expected_tiles.push_back(t);
        tiles_predicted++;
      end
      // advance the raster position
      if (col_pos + 1 >= w) begin
        col_pos = 0;
        col_in_tile = 0;
        col_tile = 0;
        if (row_pos + 1 >= h) begin
          row_pos = 0;
          row_in_tile = 0;
        end else begin
          row_pos++;
          row_in_tile = (row_in_tile + 1 >= bh) ? 0 : row_in_tile + 1;
        end
      end else begin
        col_pos++;
        if (col_in_tile + 1 >= bw) begin
          col_in_tile = 0;
          col_tile = (col_tile + 1) & 12'hFFF;
        end else begin
          col_in_tile++;
        end
      end
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] seen);
      if (seen !== want)
        flag($sformatf("tile %0d %s mismatch: expected %0d, got %0d",
                       tiles_checked, field, want, seen));
    endfunction

    function void check_result(stats_t got);
      stats_t want;
      if (expected_tiles.size() == 0) begin
        flag($sformatf("tile result with nothing predicted: row %0d col %0d",
                       got.block_row, got.block_col));
        return;
      end
      want = expected_tiles.pop_front();
      compare_field("block_row",   32'(want.block_row),   32'(got.block_row));
      compare_field("block_col",   32'(want.block_col),   32'(got.block_col));
      compare_field("block_min",   32'(want.block_min),   32'(got.block_min));
      compare_field("block_max",   32'(want.block_max),   32'(got.block_max));
      compare_field("pixel_sum",   32'(want.pixel_sum),   32'(got.pixel_sum));
      compare_field("pixel_count", 32'(want.pixel_count), 32'(got.pixel_count));
      compare_field("mean_int",    32'(want.mean_int),    32'(got.mean_int));
      compare_field("mean_frac",   32'(want.mean_frac),   32'(got.mean_frac));
      tiles_checked++;
    endfunction

    function int pending();
      return expected_tiles.size();
    endfunction

    function void drop_missing();
      flag($sformatf("%0d predicted tile results never arrived", expected_tiles.size()));
      expected_tiles.delete();
    endfunction
  endclass

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bmms_pixel_if pixel_ch ();
  bmms_cfg_if   cfg_ch ();
  bmms_stats_if stats_ch ();

  tile_stats_scoreboard sb = new();

  reg_write_t     write_batch [$];
  logic [PIX_W-1:0] pixel_batch [$];
  bit             hold_request = 1'b0;
  int unsigned    pixels_sent, reg_writes, image_settings, holds_done;

  always #1 clk = ~clk;

  block_min_max_mean_stats_top dut (
    .clk   (clk),
    .rst   (rst),
    .pixel (pixel_ch),
    .cfg   (cfg_ch),
    .stats (stats_ch)
  );

  // mostly back-to-back, sometimes a short gap, now and then a long one
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'h00;
    if (r < 16) return 8'hFF;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  // size register value: mostly small, sometimes zero or oversize, junk above the used bits
  function automatic logic [CFG_DATA_W-1:0] pick_size(int unsigned typical_hi, int field_w);
    int unsigned      r, v;
    logic [CFG_DATA_W-1:0] junk;
    r = $urandom_range(0, 99);
    if (r < 10) v = 0;
    else if (r < 85) v = $urandom_range(1, typical_hi);
    else v = $urandom_range(typical_hi + 1, (1 << field_w) - 1);
    junk = CFG_DATA_W'($urandom);
    return (junk << field_w) | CFG_DATA_W'(v);
  endfunction

  function automatic void queue_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    write_batch.push_back({idx, data});
  endfunction

  // one config transaction per queued write, valid kept high between them
  task automatic program_registers();
    reg_write_t wr;
    while (write_batch.size() > 0) begin
      wr = write_batch.pop_front();
      cfg_ch.valid      <= 1'b1;
      cfg_ch.reg_index  <= wr.idx;
      cfg_ch.write_data <= wr.data;
      @(posedge clk);
      while (cfg_ch.ready !== 1'b1) @(posedge clk);
      sb.write_register(wr.idx, wr.data);
      reg_writes++;
    end
    cfg_ch.valid <= 1'b0;
    image_settings++;
  endtask

  // pixel transactions from pixel_batch, with random idle gaps unless told otherwise
  task automatic stream_pixels(input bit no_gaps);
    logic [PIX_W-1:0] px;
    int               gap;
    while (pixel_batch.size() > 0) begin
      px = pixel_batch.pop_front();
      pixel_ch.valid       <= 1'b1;
      pixel_ch.pixel_value <= px;
      @(posedge clk);
      while (pixel_ch.ready !== 1'b1) @(posedge clk);
      sb.note_pixel(px);
      pixels_sent++;
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
        pixel_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    pixel_ch.valid <= 1'b0;
  endtask

  // block is idle once every predicted tile is back and the pipeline has settled
  task automatic drain_results();
    int waited;
    waited = 0;
    while (sb.pending() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (sb.pending() > 0) sb.drop_missing();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side: ready in random stretches, plus one long hold-off on request
  initial begin : result_sink
    int unsigned r, len;
    bit          rdy;
    stats_t      got;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        rdy = 1'b0;
        len = HOLD_CYCLES;
        holds_done++;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          rdy = 1'b1;
          len = $urandom_range(1, 20);
        end else if (r < 95) begin
          rdy = 1'b0;
          len = $urandom_range(1, 3);
        end else begin
          rdy = 1'b0;
          len = $urandom_range(20, 60);
        end
      end
      stats_ch.ready <= rdy;
      repeat (len) begin
        @(posedge clk);
        if (stats_ch.valid === 1'b1 && stats_ch.ready === 1'b1) begin
          got.block_row   = stats_ch.block_row;
          got.block_col   = stats_ch.block_col;
          got.block_min   = stats_ch.block_min;
          got.block_max   = stats_ch.block_max;
          got.pixel_sum   = stats_ch.pixel_sum;
          got.pixel_count = stats_ch.pixel_count;
          got.mean_int    = stats_ch.mean_int;
          got.mean_frac   = stats_ch.mean_frac;
          sb.check_result(got);
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned      r, n, area, random_pixels;
    bit               no_gaps, flat;
    logic [PIX_W-1:0] level;

    pixel_ch.valid       <= 1'b0;
    pixel_ch.pixel_value <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.reg_index     <= '0;
    cfg_ch.write_data    <= '0;
    random_pixels = 0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset sizes: 1024 x 1024 image, 1 x 1 tiles, one result per pixel
    pixel_batch = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h0F, 8'hF0};
    stream_pixels(1'b1);
    drain_results();

    // zero sizes act as one, so every pixel is a whole image and wraps
    queue_write(CFG_IMAGE_WIDTH, 16'h0000);
    queue_write(CFG_IMAGE_HEIGHT, 16'h0000);
    queue_write(CFG_BLOCK_WIDTH, 16'h0000);
    queue_write(CFG_BLOCK_HEIGHT, 16'h0000);
    program_registers();
    pixel_batch = '{8'h12, 8'hFE, 8'h01};
    stream_pixels(1'b0);
    drain_results();

    // oversize tile clipped to a 3 x 2 image, the image split around unused indexes
    queue_write(CFG_IMAGE_WIDTH, 16'd3);
    queue_write(CFG_IMAGE_HEIGHT, 16'd2);
    queue_write(CFG_BLOCK_WIDTH, 16'hFFFF);
    queue_write(CFG_BLOCK_HEIGHT, 16'd300);
    program_registers();
    pixel_batch = '{8'd10, 8'd200, 8'd7};
    stream_pixels(1'b0);
    drain_results();
    // unused indexes must neither store nor restart the image
    queue_write(CFG_UNUSED_LO, 16'hFFFF);
    queue_write(CFG_UNUSED_HI, 16'h5A5A);
    program_registers();
    pixel_batch = '{8'd255, 8'd0, 8'd128};
    stream_pixels(1'b0);
    drain_results();

    // oversize image dims clamp to the maximum; 2 x 1 tiles give half-step means
    queue_write(CFG_IMAGE_WIDTH, 16'hFFFF);
    queue_write(CFG_IMAGE_HEIGHT, 16'd5000);
    queue_write(CFG_BLOCK_WIDTH, 16'hFE02);
    queue_write(CFG_BLOCK_HEIGHT, 16'hFE01);
    program_registers();
    pixel_batch = '{8'd1, 8'd2, 8'd3, 8'd4};
    stream_pixels(1'b1);
    drain_results();

    // backpressure: results held off while pixels keep coming, input must stall
    queue_write(CFG_IMAGE_WIDTH, 16'd5);
    queue_write(CFG_IMAGE_HEIGHT, 16'd4);
    queue_write(CFG_BLOCK_WIDTH, 16'd1);
    queue_write(CFG_BLOCK_HEIGHT, 16'd1);
    program_registers();
    hold_request = 1'b1;
    repeat (20) pixel_batch.push_back(pick_pixel());
    random_pixels += 20;
    stream_pixels(1'b1);
    drain_results();

    // random settings, some phases whole small images, others cut off mid-image
    while (random_pixels < RANDOM_PIXELS) begin
      if ($urandom_range(0, 99) < 60) queue_write(CFG_IMAGE_WIDTH, pick_size(24, DIM_W));
      if ($urandom_range(0, 99) < 60) queue_write(CFG_IMAGE_HEIGHT, pick_size(12, DIM_W));
      if ($urandom_range(0, 99) < 60) queue_write(CFG_BLOCK_WIDTH, pick_size(6, BLK_W));
      if ($urandom_range(0, 99) < 60) queue_write(CFG_BLOCK_HEIGHT, pick_size(6, BLK_W));
      if ($urandom_range(0, 99) < 15)
        queue_write(CFG_IDX_W'($urandom_range(CFG_UNUSED_LO, CFG_UNUSED_HI)),
                    CFG_DATA_W'($urandom));
      if (write_batch.size() > 0) program_registers();

      area = sb.image_area();
      r = $urandom_range(0, 99);
      if (r < 50 && area <= 48) n = area * $urandom_range(1, 48 / area);
      else n = $urandom_range(1, 40);

      flat    = ($urandom_range(0, 99) < 10);
      level   = pick_pixel();
      no_gaps = ($urandom_range(0, 99) < 30);
      repeat (n) pixel_batch.push_back(flat ? level : pick_pixel());
      random_pixels += n;
      stream_pixels(no_gaps);
      drain_results();
    end

    $display("covered %0d pixels over %0d size settings, %0d register writes, %0d long hold-offs",
             pixels_sent, image_settings, reg_writes, holds_done);
    $display("%0d tile results checked, %0d failures", sb.tiles_checked, sb.failures);
    if (sb.failures == 0) begin
      $display("block_min_max_mean_stats_top verification clean");
    end else begin
      $display("block_min_max_mean_stats_top verification failed");
    end
    $finish;
  end

  // watchdog for a hung handshake
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("timeout with %0d tile results outstanding", sb.pending());
    $display("block_min_max_mean_stats_top verification failed");
    $finish;
  end

endmodule
